// File: hdl/mfp_pkg.sv
// Shared types and constants for the message frame parser.
// Used by all modules of the block; depends on nothing.
package mfp_pkg;

	localparam logic [7:0] CH_OPEN      = 8'h7B;
	localparam logic [7:0] CH_BAR       = 8'h7C;
	localparam logic [7:0] CH_CLOSE     = 8'h7D;
	localparam logic [7:0] VERSION_TYPE = 8'h7F;
	localparam int         RESPONSE_BIT = 7;

	localparam logic [3:0] PH_HUNT      = 4'd0;
	localparam logic [3:0] PH_LEN_HI    = 4'd1;
	localparam logic [3:0] PH_LEN_LO    = 4'd2;
	localparam logic [3:0] PH_SEP       = 4'd3;
	localparam logic [3:0] PH_TYPE      = 4'd4;
	localparam logic [3:0] PH_TAG       = 4'd5;
	localparam logic [3:0] PH_RET       = 4'd6;
	localparam logic [3:0] PH_DATA      = 4'd7;
	localparam logic [3:0] PH_TERM      = 4'd8;
	localparam logic [3:0] PH_SKIP_TYPE = 4'd9;
	localparam logic [3:0] PH_SKIP_TAG  = 4'd10;

	localparam logic [2:0] KIND_HEADER   = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
	localparam logic [2:0] KIND_GOOD     = 3'd2;
	localparam logic [2:0] KIND_BAD_SEP  = 3'd3;
	localparam logic [2:0] KIND_BAD_TERM = 3'd4;
	localparam logic [2:0] KIND_BLOCKED  = 3'd5;

	localparam int          ADDR_W          = 3;
	localparam logic        REG_STRICT      = 1'b0;
	localparam logic        REG_MATCHED     = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  msg_type;
		logic [7:0]  request_tag;
		logic [7:0]  return_code;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} result_t;

	typedef struct packed {
		logic strict_versions;
		logic versions_matched;
	} cfg_t;

endpackage

// File: hdl/mfp_cfg_regs.sv
// APB register file: strict_versions at 0x0, versions_matched at 0x4.
// Depends on mfp_pkg.
module mfp_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output mfp_pkg::cfg_t              cfg
);

	logic strict_q;
	logic matched_q;
	logic wr_en;
	logic aligned;

	assign pready  = 1'b1;
	assign aligned = (paddr[1:0] == 2'b00);
	assign wr_en   = psel & penable & pwrite & aligned;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q  <= 1'b1;
			matched_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				mfp_pkg::REG_STRICT:  strict_q  <= pwdata[0];
				mfp_pkg::REG_MATCHED: matched_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (aligned) begin
			case (paddr[2])
				mfp_pkg::REG_STRICT:  prdata = {31'd0, strict_q};
				mfp_pkg::REG_MATCHED: prdata = {31'd0, matched_q};
				default:              prdata = 32'd0;
			endcase
		end
	end

	assign cfg.strict_versions  = strict_q;
	assign cfg.versions_matched = matched_q;

endmodule

// File: hdl/mfp_parse.sv
// Frame parser state machine: one received word per accept, at most one result.
// Depends on mfp_pkg.
module mfp_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       rx_byte,
	input  mfp_pkg::cfg_t    cfg,
	output logic             res_valid,
	output mfp_pkg::result_t res
);

	logic [3:0]  phase_q, phase_n;
	logic [7:0]  len_hi_q, len_hi_n;
	logic [15:0] remaining_q, remaining_n;
	logic [15:0] length_q, length_n;
	logic [7:0]  type_q, type_n;
	logic [7:0]  tag_q, tag_n;
	logic [7:0]  ret_q, ret_n;
	logic [2:0]  kind;
	logic [7:0]  data;
	logic        blocked;

	assign blocked = cfg.strict_versions & ~cfg.versions_matched
		& (type_q != mfp_pkg::VERSION_TYPE);

	always_comb begin
		phase_n     = phase_q;
		len_hi_n    = len_hi_q;
		remaining_n = remaining_q;
		length_n    = length_q;
		type_n      = type_q;
		tag_n       = tag_q;
		ret_n       = ret_q;
		res_valid   = 1'b0;
		kind        = mfp_pkg::KIND_HEADER;
		data        = 8'd0;
		case (phase_q)
			mfp_pkg::PH_LEN_HI: begin
				len_hi_n = rx_byte;
				phase_n  = mfp_pkg::PH_LEN_LO;
			end
			mfp_pkg::PH_LEN_LO: begin
				length_n    = {len_hi_q, rx_byte};
				remaining_n = {len_hi_q, rx_byte};
				phase_n     = mfp_pkg::PH_SEP;
			end
			mfp_pkg::PH_SEP: begin
				phase_n = (rx_byte == mfp_pkg::CH_BAR) ? mfp_pkg::PH_TYPE
					: mfp_pkg::PH_SKIP_TYPE;
			end
			mfp_pkg::PH_TYPE: begin
				type_n  = rx_byte;
				phase_n = mfp_pkg::PH_TAG;
			end
			mfp_pkg::PH_SKIP_TYPE: begin
				type_n  = rx_byte;
				phase_n = mfp_pkg::PH_SKIP_TAG;
			end
			mfp_pkg::PH_SKIP_TAG: begin
				tag_n     = rx_byte;
				ret_n     = 8'd0;
				res_valid = 1'b1;
				kind      = mfp_pkg::KIND_BAD_SEP;
				phase_n   = mfp_pkg::PH_HUNT;
			end
			mfp_pkg::PH_TAG, mfp_pkg::PH_RET: begin
				if (phase_q == mfp_pkg::PH_TAG) begin
					tag_n = rx_byte;
					ret_n = 8'd0;
				end else begin
					ret_n = rx_byte;
				end
				if (phase_q == mfp_pkg::PH_TAG && type_q[mfp_pkg::RESPONSE_BIT]) begin
					phase_n = mfp_pkg::PH_RET;
				end else if (blocked) begin
					res_valid = 1'b1;
					kind      = mfp_pkg::KIND_BLOCKED;
					phase_n   = mfp_pkg::PH_HUNT;
				end else begin
					res_valid = 1'b1;
					kind      = mfp_pkg::KIND_HEADER;
					phase_n   = (remaining_q != 16'd0) ? mfp_pkg::PH_DATA
						: mfp_pkg::PH_TERM;
				end
			end
			mfp_pkg::PH_DATA: begin
				res_valid   = 1'b1;
				kind        = mfp_pkg::KIND_PAYLOAD;
				data        = rx_byte;
				remaining_n = remaining_q - 16'd1;
				if (remaining_q == 16'd1) begin
					phase_n = mfp_pkg::PH_TERM;
				end
			end
			mfp_pkg::PH_TERM: begin
				res_valid = 1'b1;
				kind      = (rx_byte == mfp_pkg::CH_CLOSE) ? mfp_pkg::KIND_GOOD
					: mfp_pkg::KIND_BAD_TERM;
				phase_n   = mfp_pkg::PH_HUNT;
			end
			default: begin
				phase_n = (rx_byte == mfp_pkg::CH_OPEN) ? mfp_pkg::PH_LEN_HI
					: mfp_pkg::PH_HUNT;
			end
		endcase
	end

	assign res.kind           = kind;
	assign res.msg_type       = type_n;
	assign res.request_tag    = tag_n;
	assign res.return_code    = ret_n;
	assign res.payload_length = length_n;
	assign res.data_byte      = data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mfp_pkg::PH_HUNT;
			len_hi_q    <= 8'd0;
			remaining_q <= 16'd0;
			length_q    <= 16'd0;
			type_q      <= 8'd0;
			tag_q       <= 8'd0;
			ret_q       <= 8'd0;
		end else if (accept) begin
			phase_q     <= phase_n;
			len_hi_q    <= len_hi_n;
			remaining_q <= remaining_n;
			length_q    <= length_n;
			type_q      <= type_n;
			tag_q       <= tag_n;
			ret_q       <= ret_n;
		end
	end

endmodule

// File: hdl/mfp_out_buf.sv
// Two-entry result register with skid slot; stall toward the input is registered.
// Depends on mfp_pkg.
module mfp_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mfp_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output mfp_pkg::result_t head
);

	logic [1:0]       count_q;
	mfp_pkg::result_t slot0_q;
	mfp_pkg::result_t slot1_q;
	logic             pop;
	logic             wr0;
	logic             wr1;
	logic             shift;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid & ~out_stall;
	assign head      = slot0_q;

	assign shift = pop & (count_q == 2'd2);
	assign wr0   = push & ((count_q == 2'd0) | (pop & (count_q == 2'd1)));
	assign wr1   = push & (count_q == 2'd1) & ~pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			slot0_q <= slot1_q;
		end else if (wr0) begin
			slot0_q <= push_data;
		end
		if (wr1) begin
			slot1_q <= push_data;
		end
	end

endmodule

// File: hdl/message_frame_parser.sv
// Top level of the message frame parser: config registers, parser, result buffer.
// Depends on mfp_pkg, mfp_cfg_regs, mfp_parse, mfp_out_buf.
//
//  channel   direction  handshake          payload
//  input     in         in_valid/in_stall  rx_byte
//  result    out        out_valid/out_stall kind, msg_type, request_tag,
//                                          return_code, payload_length, data_byte
//  config    in         APB psel/penable   paddr, pwdata, prdata
//
// One word per cycle while in_stall is low; a result is registered in the result buffer before it shows.
// in_stall rises only when both result slots hold words not yet taken.
// Reset puts the parser in hunting, strict_versions to 1, versions_matched to 0.
module message_frame_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 kind,
	output logic [7:0]                 msg_type,
	output logic [7:0]                 request_tag,
	output logic [7:0]                 return_code,
	output logic [15:0]                payload_length,
	output logic [7:0]                 data_byte,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	mfp_pkg::cfg_t    cfg;
	mfp_pkg::result_t res;
	mfp_pkg::result_t head;
	logic             res_valid;
	logic             accept;
	logic             full;

	assign in_stall = full;
	assign accept   = in_valid & ~full;

	mfp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	mfp_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept & res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind           = head.kind;
	assign msg_type       = head.msg_type;
	assign request_tag    = head.request_tag;
	assign return_code    = head.return_code;
	assign payload_length = head.payload_length;
	assign data_byte      = head.data_byte;

endmodule

// File: verif/tb_message_frame_parser.sv
// Testbench for message_frame_parser: byte stream in, frame reports out, APB config.
// Needs mfp_pkg and the parser RTL; a scoreboard class predicts every report.
module tb_message_frame_parser ();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_BYTES = 290;

	class frame_scoreboard;
		logic                strict_versions;
		logic                versions_matched;
		logic [3:0]          phase;
		logic [7:0]          len_high;
		logic [15:0]         left;
		logic [15:0]         declared_len;
		logic [7:0]          type_q;
		logic [7:0]          tag_q;
		logic [7:0]          ret_q;
		mfp_pkg::result_t    expected_reports[$];
		int                  errors;

		function new();
			strict_versions  = 1'b1;
			versions_matched = 1'b0;
			phase            = mfp_pkg::PH_HUNT;
			len_high         = '0;
			left             = '0;
			declared_len     = '0;
			type_q           = '0;
			tag_q            = '0;
			ret_q            = '0;
			errors           = 0;
		endfunction

		function void set_reg(logic sel, logic value);
			if (sel == mfp_pkg::REG_STRICT) begin
				strict_versions = value;
			end else begin
				versions_matched = value;
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void push_report(logic [2:0] k, logic [7:0] d);
			mfp_pkg::result_t r;
			r.kind           = k;
			r.msg_type       = type_q;
			r.request_tag    = tag_q;
			r.return_code    = ret_q;
			r.payload_length = declared_len;
			r.data_byte      = d;
			expected_reports.push_back(r);
		endfunction

		function void close_header();
			if (strict_versions && !versions_matched && type_q != mfp_pkg::VERSION_TYPE) begin
				push_report(mfp_pkg::KIND_BLOCKED, 8'h00);
				phase = mfp_pkg::PH_HUNT;
			end else begin
				push_report(mfp_pkg::KIND_HEADER, 8'h00);
				phase = (left != 16'd0) ? mfp_pkg::PH_DATA : mfp_pkg::PH_TERM;
			end
		endfunction

		// one accepted word from the link
		function void take_byte(logic [7:0] b);
			case (phase)
				mfp_pkg::PH_LEN_HI: begin
					len_high = b;
					phase    = mfp_pkg::PH_LEN_LO;
				end
				mfp_pkg::PH_LEN_LO: begin
					declared_len = {len_high, b};
					left         = declared_len;
					phase        = mfp_pkg::PH_SEP;
				end
				mfp_pkg::PH_SEP: begin
					phase = (b == mfp_pkg::CH_BAR) ? mfp_pkg::PH_TYPE : mfp_pkg::PH_SKIP_TYPE;
				end
				mfp_pkg::PH_TYPE, mfp_pkg::PH_SKIP_TYPE: begin
					type_q = b;
					phase  = (phase == mfp_pkg::PH_TYPE) ? mfp_pkg::PH_TAG
						: mfp_pkg::PH_SKIP_TAG;
				end
				mfp_pkg::PH_SKIP_TAG: begin
					tag_q = b;
					ret_q = 8'h00;
					push_report(mfp_pkg::KIND_BAD_SEP, 8'h00);
					phase = mfp_pkg::PH_HUNT;
				end
				mfp_pkg::PH_TAG: begin
					tag_q = b;
					if (type_q[mfp_pkg::RESPONSE_BIT]) begin
						phase = mfp_pkg::PH_RET;
					end else begin
						ret_q = 8'h00;
						close_header();
					end
				end
				mfp_pkg::PH_RET: begin
					ret_q = b;
					close_header();
				end
				mfp_pkg::PH_DATA: begin
					push_report(mfp_pkg::KIND_PAYLOAD, b);
					left = left - 16'd1;
					if (left == 16'd0) begin
						phase = mfp_pkg::PH_TERM;
					end
				end
				mfp_pkg::PH_TERM: begin
					push_report((b == mfp_pkg::CH_CLOSE) ? mfp_pkg::KIND_GOOD
						: mfp_pkg::KIND_BAD_TERM, 8'h00);
					phase = mfp_pkg::PH_HUNT;
				end
				default: begin
					phase = (b == mfp_pkg::CH_OPEN) ? mfp_pkg::PH_LEN_HI : mfp_pkg::PH_HUNT;
				end
			endcase
		endfunction

		function void compare(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_report(mfp_pkg::result_t got);
			mfp_pkg::result_t want;
			if (expected_reports.size() == 0) begin
				$error("unexpected report: kind %0d", got.kind);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			compare("kind", 32'(want.kind), 32'(got.kind));
			compare("msg_type", 32'(want.msg_type), 32'(got.msg_type));
			compare("request_tag", 32'(want.request_tag), 32'(got.request_tag));
			compare("return_code", 32'(want.return_code), 32'(got.return_code));
			compare("payload_length", 32'(want.payload_length), 32'(got.payload_length));
			compare("data_byte", 32'(want.data_byte), 32'(got.data_byte));
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [7:0]                 rx_byte = 8'h00;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [2:0]                 kind;
	logic [7:0]                 msg_type;
	logic [7:0]                 request_tag;
	logic [7:0]                 return_code;
	logic [15:0]                payload_length;
	logic [7:0]                 data_byte;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [mfp_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                pwdata = '0;
	logic [31:0]                prdata;
	logic                       pready;

	frame_scoreboard sb = new();
	bit              calm = 1'b0;
	int              framed_bytes = 0;
	int              cycles = 0;
	int              stall_left = 0;

	message_frame_parser u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.msg_type       (msg_type),
		.request_tag    (request_tag),
		.return_code    (return_code),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin : result_side
		mfp_pkg::result_t got;
		if (out_valid && !out_stall) begin
			got.kind           = kind;
			got.msg_type       = msg_type;
			got.request_tag    = request_tag;
			got.return_code    = return_code;
			got.payload_length = payload_length;
			got.data_byte      = data_byte;
			sb.check_report(got);
		end
		if (stall_left > 0) begin
			stall_left--;
		end else if (!calm && arst_n && $urandom_range(0, 3) == 0) begin
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
				: $urandom_range(1, 3);
		end
		out_stall <= (stall_left > 0);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70) begin
			return 0;
		end
		return (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		sb.take_byte(b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(sel, value);
	endtask

	// header_only stops after the header: blocked frames and bad separators
	task automatic send_frame(input logic [15:0] len, input logic [7:0] sep,
			input logic [7:0] typ, input logic [7:0] tag, input logic [7:0] ret,
			input logic [7:0] term, input bit header_only);
		logic [7:0] fb[$];
		fb = '{mfp_pkg::CH_OPEN, len[15:8], len[7:0], sep, typ, tag};
		if (sep == mfp_pkg::CH_BAR) begin
			if (typ[mfp_pkg::RESPONSE_BIT]) begin
				fb.push_back(ret);
			end
			if (!header_only) begin
				for (int i = 0; i < int'(len); i++) begin
					fb.push_back(8'($urandom_range(0, 255)));
				end
				fb.push_back(term);
			end
		end
		foreach (fb[i]) begin
			send_byte(fb[i]);
			framed_bytes++;
		end
	endtask

	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 6)) begin
			b = 8'($urandom_range(0, 255));
			if (b == mfp_pkg::CH_OPEN) begin
				b = 8'h00;
			end
			send_byte(b);
		end
	endtask

	task automatic random_frame();
		int         r;
		logic [7:0] typ;
		logic [7:0] sep;
		logic [7:0] term;
		logic [15:0] len;
		bit         gated;
		r     = $urandom_range(0, 99);
		calm  = ($urandom_range(0, 7) == 0);
		gated = sb.strict_versions && !sb.versions_matched;
		typ   = 8'($urandom_range(0, 255));
		if (gated && $urandom_range(0, 1) == 0) begin
			typ = mfp_pkg::VERSION_TYPE;
		end
		len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(7, 40))
			: 16'($urandom_range(0, 6));
		if (r < 10) begin
			send_noise();
		end else if (r < 25) begin
			sep = 8'($urandom_range(0, 255));
			if (sep == mfp_pkg::CH_BAR) begin
				sep = mfp_pkg::CH_OPEN;
			end
			send_frame(16'($urandom_range(0, 65535)), sep, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'h00, mfp_pkg::CH_CLOSE, 1'b1);
		end else if (gated && typ != mfp_pkg::VERSION_TYPE) begin
			send_frame(16'($urandom_range(0, 65535)), mfp_pkg::CH_BAR, typ,
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				mfp_pkg::CH_CLOSE, 1'b1);
		end else begin
			term = mfp_pkg::CH_CLOSE;
			if (r < 35) begin
				term = ($urandom_range(0, 2) == 0) ? mfp_pkg::CH_OPEN
					: 8'($urandom_range(0, 255));
				if (term == mfp_pkg::CH_CLOSE) begin
					term = mfp_pkg::CH_OPEN;
				end
			end
			send_frame(len, mfp_pkg::CH_BAR, typ, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), term, 1'b0);
		end
		if ($urandom_range(0, 39) == 0) begin
			drain();
		end
	endtask

	task automatic random_phase(input logic strict_v, input logic matched_v);
		int start;
		drain();
		write_reg(mfp_pkg::REG_STRICT, strict_v);
		write_reg(mfp_pkg::REG_MATCHED, matched_v);
		start = framed_bytes;
		while (framed_bytes - start < PHASE_BYTES) begin
			random_frame();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gate closed: version check passes, others blocked, bad separator
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(16'd2, mfp_pkg::CH_BAR, mfp_pkg::VERSION_TYPE, 8'h00, 8'h00,
			mfp_pkg::CH_CLOSE, 1'b0);
		send_frame(16'd5, mfp_pkg::CH_BAR, 8'h01, 8'h22, 8'h00, mfp_pkg::CH_CLOSE, 1'b1);
		send_frame(16'hFFFF, mfp_pkg::CH_BAR, 8'h80, 8'hFF, 8'h55, mfp_pkg::CH_CLOSE, 1'b1);
		send_frame(16'h1234, 8'h00, 8'h01, 8'h02, 8'h00, mfp_pkg::CH_CLOSE, 1'b1);

		drain();
		write_reg(mfp_pkg::REG_MATCHED, 1'b1);
		send_frame(16'd0, mfp_pkg::CH_BAR, 8'hFF, 8'h80, 8'hAA, mfp_pkg::CH_CLOSE, 1'b0);
		send_frame(16'd1, mfp_pkg::CH_BAR, 8'h10, 8'h20, 8'h33, mfp_pkg::CH_OPEN, 1'b0);
		send_frame(16'd0, mfp_pkg::CH_BAR, 8'h00, 8'h01, 8'h00, 8'h00, 1'b0);
		calm = 1'b1;
		send_frame(16'h0100, mfp_pkg::CH_BAR, 8'hC3, 8'h3C, 8'h00, mfp_pkg::CH_CLOSE, 1'b0);
		calm = 1'b0;

		drain();
		write_reg(mfp_pkg::REG_STRICT, 1'b0);
		write_reg(mfp_pkg::REG_MATCHED, 1'b0);
		send_frame(16'd1, mfp_pkg::CH_BAR, 8'h01, 8'h7E, 8'h00, mfp_pkg::CH_CLOSE, 1'b0);

		random_phase(1'b1, 1'b0);
		random_phase(1'b0, 1'b1);
		random_phase(1'b1, 1'b1);
		random_phase(1'b0, 1'b0);

		calm = 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
